// File: rtl/assert_macros.svh
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned CmdW  = 4;
    localparam int unsigned StW   = 3;

    typedef enum logic [3:0] {
        CMD_PUSH   = 4'd0,
        CMD_ADD    = 4'd1,
        CMD_SUB    = 4'd2,
        CMD_MUL    = 4'd3,
        CMD_DIV    = 4'd4,
        CMD_NEG    = 4'd5,
        CMD_DUP    = 4'd6,
        CMD_SWAP   = 4'd7,
        CMD_PEEK   = 4'd8,
        CMD_CLEAR  = 4'd9,
        CMD_LIST   = 4'd10
    } t_cmd;

    typedef enum logic [2:0] {
        ST_VALUE = 3'd0,
        ST_EMPTY = 3'd1,
        ST_UNDER = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_FULL  = 3'd4,
        ST_UNK   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,     // issue read of top
        S_RD_B,     // issue read of second
        S_CAP,      // capture second operand
        S_MUL,      // run adder or multiplier
        S_DIV,      // iterate divider
        S_WB,       // write result
        S_WB2,      // second write (swap)
        S_LIST_RD,
        S_LIST_OUT,
        S_OUT
    } t_state;

    // operation selected for the arithmetic unit
    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_PASS
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic          rd_en;
        logic          rd_sel_b;   // 0: index top-1 offset, 1: top-2
        logic          cap_a;      // capture read data as first
        logic          cap_b;      // capture read data as second
        logic          start;      // start multi-cycle unit
        t_op           op;
        logic          wr_en;
        logic          wr_sel;     // 0: second slot, 1: top slot
        logic          wr_dup;     // write at count (dup)
        logic          wr_second;  // write data is second (swap)
        logic          push_in;    // write operand input
        logic          list_rd;    // read at list pointer
        logic          list_init;
        logic          list_step;
    } t_ctrl;

    typedef struct packed {
        logic busy;      // multi-cycle unit busy
        logic first_zero;
        logic list_done; // pointer at bottom entry
    } t_stat;

endpackage

// File: rtl/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top
// RPN integer calculator on a bounded stack of 64-bit values.
// ----------------------------------------------------------------------------
// One command is taken at a time. Push and clear finish at accept; an error
// found at accept gives a status item. Peek reads the top once. Add, sub, neg,
// dup and swap read two stack entries, and swap writes two; mul goes through a
// 32x32 multiplier used for three partial products; div goes through the
// restoring divider, one quotient bit per cycle. List gives one item per
// memory read, each held until the output takes it. Results leave
// through a registered output; a new command is taken once it drains.
module rpn_stack_calculator_top #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [3:0] command, [67:4] operand_value, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] result_value
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    rpn_pkg::t_ctrl ctrl;
    rpn_pkg::t_stat stat;
    logic [CW-1:0]  count;
    logic [63:0]    rd_val, r_val;
    logic           sel_val, ov, r_ov;

    rpn_ctrl #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[3:0]),
        .i_out_ready(m_axis_tready), .o_out_valid(ov),
        .o_out_status(m_axis_tuser), .o_out_last(m_axis_tlast),
        .o_out_sel_val(sel_val),
        .i_stat(stat), .o_ctrl(ctrl), .o_count(count)
    );

    rpn_dp #(.STACK_DEPTH(STACK_DEPTH), .AW(AW), .CW(CW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctrl(ctrl), .i_count(count), .i_operand(s_axis_tdata[67:4]),
        .o_stat(stat), .o_out_value(rd_val)
    );

    // value latched alongside the output register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else r_ov <= ov;
        if (ov && !r_ov) r_val <= rd_val;
        else if (ov && m_axis_tready) r_val <= rd_val;
    end

    assign m_axis_tvalid = ov;
    assign m_axis_tdata  = sel_val ? (r_ov ? r_val : rd_val) : 64'd0;
endmodule

// File: rtl/rpn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_dp
// Stack memory, operand registers, adder, staged multiplier, serial divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rpn_dp #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned AW = 5,
    parameter int unsigned CW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rpn_pkg::t_ctrl            i_ctrl,
    input  logic [CW-1:0]             i_count,
    input  logic [rpn_pkg::DataW-1:0] i_operand,
    output rpn_pkg::t_stat            o_stat,
    output logic [rpn_pkg::DataW-1:0] o_out_value
);
    localparam int unsigned W = rpn_pkg::DataW;

    logic [W-1:0] r_mem [STACK_DEPTH];
    logic [W-1:0] r_rdata;
    logic [W-1:0] r_first, r_second, r_res;
    logic [AW-1:0] r_lptr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [W-1:0] wr_data;

    // multiplier: three 32x32 partial products over cycles
    logic [1:0]   r_mstep;
    logic [W-1:0] r_macc;
    logic [31:0]  ma, mb;
    logic [W-1:0] r_pp;
    logic         r_mbusy, r_ppv;

    // divider: restoring, one quotient bit per cycle
    logic [W-1:0] r_dq, r_drem, r_dden;
    logic [6:0]   r_dcnt;
    logic         r_dbusy, r_dneg;
    logic [W:0]   dtrial;

    assign rd_addr = i_ctrl.list_rd ? r_lptr :
                     (i_ctrl.rd_sel_b ? AW'(i_count - CW'(2)) : AW'(i_count - CW'(1)));
    assign wr_addr = (i_ctrl.push_in || i_ctrl.wr_dup) ? AW'(i_count) :
                     (i_ctrl.wr_sel ? AW'(i_count - CW'(1)) : AW'(i_count - CW'(2)));

    always_comb begin
        wr_data = r_res;
        if (i_ctrl.push_in) wr_data = i_operand;
        else if (i_ctrl.wr_second) wr_data = r_second;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) r_mem[wr_addr] <= wr_data;
        if (i_ctrl.rd_en || i_ctrl.list_rd) r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        case (r_mstep)
            2'd0:    begin ma = r_second[31:0];  mb = r_first[31:0];  end
            2'd1:    begin ma = r_second[63:32]; mb = r_first[31:0];  end
            2'd2:    begin ma = r_second[31:0];  mb = r_first[63:32]; end
            default: begin ma = r_second[31:0];  mb = r_first[31:0];  end
        endcase
    end

    assign dtrial = {r_drem[W-2:0], r_dq[W-1]} - {1'b0, r_dden};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_ppv   <= 1'b0;
            r_dbusy <= 1'b0;
            r_mstep <= 2'd0;
            r_dcnt  <= 7'd0;
        end else begin
            if (i_ctrl.cap_a) r_first  <= r_rdata;
            if (i_ctrl.cap_b) r_second <= r_rdata;
            if (i_ctrl.list_init) r_lptr <= AW'(i_count - CW'(1));
            else if (i_ctrl.list_step) r_lptr <= r_lptr - AW'(1);

            if (i_ctrl.start) begin
                case (i_ctrl.op)
                    rpn_pkg::OP_ADD:  r_res <= r_second + r_first;
                    rpn_pkg::OP_SUB:  r_res <= r_second - r_first;
                    rpn_pkg::OP_NEG:  r_res <= W'(0) - r_first;
                    rpn_pkg::OP_PASS: r_res <= r_first;
                    rpn_pkg::OP_MUL: begin
                        r_mbusy <= 1'b1;
                        r_mstep <= 2'd0;
                        r_macc  <= '0;
                        r_ppv   <= 1'b0;
                    end
                    rpn_pkg::OP_DIV: begin
                        r_dbusy <= 1'b1;
                        r_dcnt  <= 7'd0;
                        r_drem  <= '0;
                        r_dq    <= r_second[W-1] ? W'(0) - r_second : r_second;
                        r_dden  <= r_first[W-1] ? W'(0) - r_first : r_first;
                        r_dneg  <= r_second[W-1] ^ r_first[W-1];
                    end
                    default: r_res <= r_first;
                endcase
            end else if (r_mbusy) begin
                // pipelined: product registered, then accumulated
                r_pp  <= {32'd0, ma} * {32'd0, mb};
                r_ppv <= (r_mstep != 2'd3);
                if (r_ppv) begin
                    case (r_mstep)
                        2'd1:    r_macc <= r_macc + r_pp;
                        default: r_macc <= r_macc + {r_pp[31:0], 32'd0};
                    endcase
                end
                if (r_mstep == 2'd3) begin
                    r_res   <= r_macc + {r_pp[31:0], 32'd0};
                    r_mbusy <= 1'b0;
                end else begin
                    r_mstep <= r_mstep + 2'd1;
                end
            end else if (r_dbusy) begin
                if (r_dcnt == 7'(W)) begin
                    r_res   <= r_dneg ? W'(0) - r_dq : r_dq;
                    r_dbusy <= 1'b0;
                end else begin
                    if (!dtrial[W]) begin
                        r_drem <= dtrial[W-1:0];
                        r_dq   <= {r_dq[W-2:0], 1'b1};
                    end else begin
                        r_drem <= {r_drem[W-2:0], r_dq[W-1]};
                        r_dq   <= {r_dq[W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 7'd1;
                end
            end
        end
    end

    assign o_stat.busy       = r_mbusy | r_dbusy;
    assign o_stat.first_zero = (r_first == '0);
    assign o_stat.list_done  = (r_lptr == '0);
    assign o_out_value       = r_rdata;

    `ASSERT_NEVER(a_both_busy, i_clk, i_rst_n, r_mbusy && r_dbusy)
    `ASSERT_CLK(a_start_idle, i_clk, i_rst_n, i_ctrl.start |-> !(r_mbusy || r_dbusy))
    `ASSERT_CLK(a_div_ends, i_clk, i_rst_n, (r_dbusy && r_dcnt == 7'(W)) |=> !r_dbusy)
endmodule

// File: rtl/rpn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ctrl
// Command sequencer: checks, stack count, read/write and output control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rpn_ctrl #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned CW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rpn_pkg::CmdW-1:0]  i_cmd,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [rpn_pkg::StW-1:0]   o_out_status,
    output logic                      o_out_last,
    output logic                      o_out_sel_val,
    input  rpn_pkg::t_stat            i_stat,
    output rpn_pkg::t_ctrl            o_ctrl,
    output logic [CW-1:0]             o_count
);
    rpn_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [rpn_pkg::CmdW-1:0] r_cmd;
    logic            r_ovalid, r_olast, r_osel;
    rpn_pkg::t_status r_ost;
    logic            out_free, acc;
    logic            r_wait;

    function automatic rpn_pkg::t_status status_of(input logic [rpn_pkg::CmdW-1:0] c,
                                                   input logic [CW-1:0] n,
                                                   input rpn_pkg::t_state s);
        rpn_pkg::t_status st;
        st = rpn_pkg::ST_VALUE;
        if (s == rpn_pkg::S_OUT) begin
            case (rpn_pkg::t_cmd'(c))
                rpn_pkg::CMD_PUSH: st = rpn_pkg::ST_FULL;
                rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_SWAP:
                    st = rpn_pkg::ST_UNDER;
                rpn_pkg::CMD_DIV: st = (n < CW'(2)) ? rpn_pkg::ST_UNDER : rpn_pkg::ST_DIVZ;
                rpn_pkg::CMD_NEG: st = rpn_pkg::ST_UNDER;
                rpn_pkg::CMD_PEEK: st = (n == '0) ? rpn_pkg::ST_UNDER : rpn_pkg::ST_VALUE;
                rpn_pkg::CMD_DUP: st = (n == '0) ? rpn_pkg::ST_UNDER : rpn_pkg::ST_FULL;
                rpn_pkg::CMD_LIST: st = rpn_pkg::ST_EMPTY;
                default: st = rpn_pkg::ST_UNK;
            endcase
        end
        return st;
    endfunction

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == rpn_pkg::S_IDLE) && !r_ovalid;
    assign acc        = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            rpn_pkg::S_IDLE: if (acc) begin
                case (rpn_pkg::t_cmd'(i_cmd))
                    rpn_pkg::CMD_PUSH: if (r_count != CW'(STACK_DEPTH)) begin
                        n_count = r_count + CW'(1);
                    end else n_state = rpn_pkg::S_OUT;
                    rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
                    rpn_pkg::CMD_DIV, rpn_pkg::CMD_SWAP:
                        n_state = (r_count < CW'(2)) ? rpn_pkg::S_OUT : rpn_pkg::S_RD_A;
                    rpn_pkg::CMD_NEG, rpn_pkg::CMD_PEEK:
                        n_state = (r_count == '0) ? rpn_pkg::S_OUT : rpn_pkg::S_RD_A;
                    rpn_pkg::CMD_DUP:
                        n_state = (r_count == '0 || r_count == CW'(STACK_DEPTH)) ?
                                  rpn_pkg::S_OUT : rpn_pkg::S_RD_A;
                    rpn_pkg::CMD_CLEAR: n_count = '0;
                    rpn_pkg::CMD_LIST:
                        n_state = (r_count == '0) ? rpn_pkg::S_OUT : rpn_pkg::S_LIST_RD;
                    default: n_state = rpn_pkg::S_OUT;
                endcase
            end
            // peek only needs the top entry
            rpn_pkg::S_RD_A:
                n_state = (rpn_pkg::t_cmd'(r_cmd) == rpn_pkg::CMD_PEEK) ?
                          rpn_pkg::S_OUT : rpn_pkg::S_RD_B;
            rpn_pkg::S_RD_B: n_state = rpn_pkg::S_CAP;
            rpn_pkg::S_CAP: begin
                case (rpn_pkg::t_cmd'(r_cmd))
                    rpn_pkg::CMD_MUL:  n_state = rpn_pkg::S_MUL;
                    rpn_pkg::CMD_DIV:  n_state = rpn_pkg::S_DIV;
                    default:           n_state = rpn_pkg::S_MUL;
                endcase
            end
            rpn_pkg::S_MUL: if (r_wait && !i_stat.busy) n_state = rpn_pkg::S_WB;
            rpn_pkg::S_DIV: begin
                if (i_stat.first_zero && !r_wait) n_state = rpn_pkg::S_OUT;
                else if (r_wait && !i_stat.busy) n_state = rpn_pkg::S_WB;
            end
            rpn_pkg::S_WB: begin
                case (rpn_pkg::t_cmd'(r_cmd))
                    rpn_pkg::CMD_SWAP: n_state = rpn_pkg::S_WB2;
                    rpn_pkg::CMD_DUP: begin
                        n_count = r_count + CW'(1);
                        n_state = rpn_pkg::S_IDLE;
                    end
                    rpn_pkg::CMD_NEG: n_state = rpn_pkg::S_IDLE;
                    default: begin
                        n_count = r_count - CW'(1);
                        n_state = rpn_pkg::S_IDLE;
                    end
                endcase
            end
            rpn_pkg::S_WB2:     n_state = rpn_pkg::S_IDLE;
            rpn_pkg::S_LIST_RD: n_state = rpn_pkg::S_LIST_OUT;
            rpn_pkg::S_LIST_OUT: if (out_free) begin
                n_state = i_stat.list_done ? rpn_pkg::S_IDLE : rpn_pkg::S_LIST_RD;
            end
            rpn_pkg::S_OUT: if (out_free) n_state = rpn_pkg::S_IDLE;
            default: n_state = rpn_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        o_ctrl.op = rpn_pkg::OP_PASS;
        case (r_state)
            rpn_pkg::S_IDLE: begin
                o_ctrl.list_init = acc;
                if (acc && rpn_pkg::t_cmd'(i_cmd) == rpn_pkg::CMD_PUSH &&
                    r_count != CW'(STACK_DEPTH)) begin
                    o_ctrl.push_in = 1'b1;
                    o_ctrl.wr_en   = 1'b1;
                end
            end
            rpn_pkg::S_RD_A: o_ctrl.rd_en = 1'b1;
            rpn_pkg::S_RD_B: begin
                o_ctrl.rd_en = 1'b1;
                o_ctrl.rd_sel_b = 1'b1;
                o_ctrl.cap_a = 1'b1;
            end
            rpn_pkg::S_CAP: o_ctrl.cap_b = 1'b1;
            rpn_pkg::S_MUL, rpn_pkg::S_DIV: begin
                o_ctrl.start = !r_wait && !(r_state == rpn_pkg::S_DIV && i_stat.first_zero);
                case (rpn_pkg::t_cmd'(r_cmd))
                    rpn_pkg::CMD_ADD: o_ctrl.op = rpn_pkg::OP_ADD;
                    rpn_pkg::CMD_SUB: o_ctrl.op = rpn_pkg::OP_SUB;
                    rpn_pkg::CMD_MUL: o_ctrl.op = rpn_pkg::OP_MUL;
                    rpn_pkg::CMD_DIV: o_ctrl.op = rpn_pkg::OP_DIV;
                    rpn_pkg::CMD_NEG: o_ctrl.op = rpn_pkg::OP_NEG;
                    default:          o_ctrl.op = rpn_pkg::OP_PASS;
                endcase
            end
            rpn_pkg::S_WB: begin
                // dup writes top copy at count; neg rewrites top; swap puts first in second slot
                o_ctrl.wr_en = 1'b1;
                case (rpn_pkg::t_cmd'(r_cmd))
                    rpn_pkg::CMD_DUP:  o_ctrl.wr_dup = 1'b1;
                    rpn_pkg::CMD_NEG:  o_ctrl.wr_sel = 1'b1;
                    default:           o_ctrl.wr_sel = 1'b0;
                endcase
            end
            rpn_pkg::S_WB2: begin
                o_ctrl.wr_en = 1'b1;
                o_ctrl.wr_sel = 1'b1;
                o_ctrl.wr_second = 1'b1;
            end
            rpn_pkg::S_LIST_RD: o_ctrl.list_rd = 1'b1;
            rpn_pkg::S_LIST_OUT: o_ctrl.list_step = out_free;
            default: ;
        endcase
    end

    // state, count and output registers; wait flag: unit started, result pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rpn_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (acc) r_cmd <= i_cmd;
            r_wait <= (r_state == rpn_pkg::S_MUL || r_state == rpn_pkg::S_DIV) &&
                      n_state == r_state;
            if ((r_state == rpn_pkg::S_OUT || r_state == rpn_pkg::S_LIST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
                r_osel   <= (r_state == rpn_pkg::S_LIST_OUT) ||
                            (rpn_pkg::t_cmd'(r_cmd) == rpn_pkg::CMD_PEEK && r_count != '0);
                r_olast  <= (r_state == rpn_pkg::S_OUT) || i_stat.list_done;
                r_ost    <= status_of(r_cmd, r_count, r_state);
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_status  = r_ost;
    assign o_out_last    = r_olast;
    assign o_out_sel_val = r_osel;
    assign o_count       = r_count;

    `ASSERT_CLK(a_count_max, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH))
    `ASSERT_NEVER(a_accept_busy, i_clk, i_rst_n, acc && r_state != rpn_pkg::S_IDLE)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (r_ovalid && !i_out_ready) |=> r_ovalid)
endmodule
